FILE: src/boolean_rule_stack_machine_top_defines.svh
// assertion macros shared by the rule stack machine rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef BOOLEAN_RULE_STACK_MACHINE_TOP_DEFINES_SVH
`define BOOLEAN_RULE_STACK_MACHINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BRSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/brsm_pkg.sv
// shared types and codes for the rule stack machine
// no dependencies
package brsm_pkg;

    // instruction modes
    localparam logic [2:0] MODE_PUSH_BOOL = 3'd0;
    localparam logic [2:0] MODE_PUSH_DEST = 3'd1;
    localparam logic [2:0] MODE_AND       = 3'd2;
    localparam logic [2:0] MODE_OR        = 3'd3;
    localparam logic [2:0] MODE_APPLY     = 3'd4;
    localparam logic [2:0] MODE_NOT       = 3'd5;
    localparam logic [2:0] MODE_POP       = 3'd6;
    localparam logic [2:0] MODE_BAIL      = 3'd7;

    // fault codes
    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_COUNT = 2'd1;
    localparam logic [1:0] FAULT_TYPE  = 2'd2;
    localparam logic [1:0] FAULT_FULL  = 2'd3;

    // per-cell update
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD      = 2'd0;
    localparam t_cell_op CELL_TAKE_PREV = 2'd1;
    localparam t_cell_op CELL_TAKE_NEXT = 2'd2;

    typedef struct packed {
        t_cell_op top_op;
        t_cell_op rest_op;
    } t_stack_cmd;

    typedef struct packed {
        logic       fire;
        logic       value;
        logic [1:0] fault;
        logic       ignored;
        logic       bailed;
    } t_res_flags;

endpackage

FILE: src/brsm_cell.sv
// one stack entry of the cell chain
// depends on brsm_pkg
module brsm_cell #(
    parameter int ENTRY_BITS = 9
) (
    input  logic                  i_clk,
    input  brsm_pkg::t_cell_op    i_op,
    input  logic [ENTRY_BITS-1:0] i_prev,
    input  logic [ENTRY_BITS-1:0] i_next,
    output logic [ENTRY_BITS-1:0] o_entry
);

    logic [ENTRY_BITS-1:0] r_entry;
    logic [ENTRY_BITS-1:0] n_entry;

    always_comb begin
        case (i_op)
            brsm_pkg::CELL_TAKE_PREV: n_entry = i_prev;
            brsm_pkg::CELL_TAKE_NEXT: n_entry = i_next;
            default:                  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: src/brsm_ctrl.sv
// instruction decode, entry count and skip flag
// depends on brsm_pkg and the assertion macro header
`include "boolean_rule_stack_machine_top_defines.svh"

module brsm_ctrl #(
    parameter int STACK_DEPTH = 16,
    parameter int DEST_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [2:0]            i_mode,
    input  logic                  i_bool_value,
    input  logic [DEST_BITS-1:0]  i_dest_index,
    input  logic                  i_last,
    input  logic [DEST_BITS:0]    i_top,
    input  logic [DEST_BITS:0]    i_second,
    output brsm_pkg::t_stack_cmd  o_cmd,
    output logic [DEST_BITS:0]    o_new_entry,
    output brsm_pkg::t_res_flags  o_flags,
    output logic [DEST_BITS-1:0]  o_dest
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_skip;
    logic                  n_skip;
    logic [1:0]            w_need;
    brsm_pkg::t_stack_cmd  w_cmd;
    brsm_pkg::t_res_flags  w_flags;
    logic [DEST_BITS:0]    w_new;
    logic [DEST_BITS-1:0]  w_dest;
    logic                  w_top_dest;
    logic                  w_sec_dest;

    // type bit set means destination
    assign w_top_dest = i_top[DEST_BITS];
    assign w_sec_dest = i_second[DEST_BITS];

    always_comb begin
        case (i_mode)
            brsm_pkg::MODE_PUSH_BOOL,
            brsm_pkg::MODE_PUSH_DEST: w_need = 2'd0;
            brsm_pkg::MODE_AND,
            brsm_pkg::MODE_OR,
            brsm_pkg::MODE_APPLY:     w_need = 2'd2;
            default:                  w_need = 2'd1;
        endcase
    end

    always_comb begin
        w_cmd.top_op  = brsm_pkg::CELL_HOLD;
        w_cmd.rest_op = brsm_pkg::CELL_HOLD;
        w_new         = '0;
        w_flags       = '0;
        w_dest        = '0;
        n_count       = r_count;
        n_skip        = r_skip;
        if (r_skip) begin
            w_flags.ignored = 1'b1;
        end else if (r_count < CNT_W'(w_need)) begin
            w_flags.fault = brsm_pkg::FAULT_COUNT;
        end else begin
            case (i_mode)
                brsm_pkg::MODE_PUSH_BOOL,
                brsm_pkg::MODE_PUSH_DEST: begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        w_flags.fault = brsm_pkg::FAULT_FULL;
                    end else begin
                        w_cmd.top_op  = brsm_pkg::CELL_TAKE_PREV;
                        w_cmd.rest_op = brsm_pkg::CELL_TAKE_PREV;
                        if (i_mode == brsm_pkg::MODE_PUSH_DEST) begin
                            w_new = {1'b1, i_dest_index};
                        end else begin
                            w_new = {{DEST_BITS{1'b0}}, i_bool_value};
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                brsm_pkg::MODE_AND,
                brsm_pkg::MODE_OR: begin
                    if (w_top_dest || w_sec_dest) begin
                        w_flags.fault = brsm_pkg::FAULT_TYPE;
                    end else begin
                        // result lands on top, the rest moves up one
                        w_cmd.top_op  = brsm_pkg::CELL_TAKE_PREV;
                        w_cmd.rest_op = brsm_pkg::CELL_TAKE_NEXT;
                        if (i_mode == brsm_pkg::MODE_AND) begin
                            w_new = {{DEST_BITS{1'b0}}, i_top[0] & i_second[0]};
                        end else begin
                            w_new = {{DEST_BITS{1'b0}}, i_top[0] | i_second[0]};
                        end
                        n_count = r_count - 1'b1;
                    end
                end
                brsm_pkg::MODE_APPLY: begin
                    if (w_sec_dest || !w_top_dest) begin
                        w_flags.fault = brsm_pkg::FAULT_TYPE;
                    end else begin
                        w_flags.fire  = 1'b1;
                        w_flags.value = i_second[0];
                        w_dest        = i_top[DEST_BITS-1:0];
                        w_cmd.top_op  = brsm_pkg::CELL_TAKE_NEXT;
                        w_cmd.rest_op = brsm_pkg::CELL_TAKE_NEXT;
                        n_count       = r_count - 1'b1;
                    end
                end
                brsm_pkg::MODE_NOT: begin
                    if (w_top_dest) begin
                        w_flags.fault = brsm_pkg::FAULT_TYPE;
                    end else begin
                        w_cmd.top_op = brsm_pkg::CELL_TAKE_PREV;
                        w_new        = {{DEST_BITS{1'b0}}, ~i_top[0]};
                    end
                end
                brsm_pkg::MODE_POP: begin
                    w_cmd.top_op  = brsm_pkg::CELL_TAKE_NEXT;
                    w_cmd.rest_op = brsm_pkg::CELL_TAKE_NEXT;
                    n_count       = r_count - 1'b1;
                end
                default: begin
                    // bail
                    if (w_top_dest) begin
                        w_flags.fault = brsm_pkg::FAULT_TYPE;
                    end else begin
                        w_cmd.top_op  = brsm_pkg::CELL_TAKE_NEXT;
                        w_cmd.rest_op = brsm_pkg::CELL_TAKE_NEXT;
                        n_count       = r_count - 1'b1;
                        if (i_top[0]) begin
                            n_skip         = 1'b1;
                            w_flags.bailed = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (w_flags.fault != brsm_pkg::FAULT_OK) begin
            n_skip = 1'b1;
        end
        if (i_last) begin
            n_count = '0;
            n_skip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_skip  <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_skip  <= n_skip;
        end
    end

    always_comb begin
        o_cmd = w_cmd;
        if (!i_accept) begin
            o_cmd.top_op  = brsm_pkg::CELL_HOLD;
            o_cmd.rest_op = brsm_pkg::CELL_HOLD;
        end
    end

    assign o_new_entry = w_new;
    assign o_flags     = w_flags;
    assign o_dest      = w_dest;

    `BRSM_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last, (r_count == '0) && !r_skip, "end of program did not clear stack state")
    `BRSM_ASSERT_NEXT(a_fault_skips, i_clk, i_rst_n, i_accept && !i_last && (w_flags.fault != brsm_pkg::FAULT_OK), r_skip, "fault did not start skipping")
    `BRSM_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH), "entry count beyond stack depth")
    `BRSM_ASSERT_NOW(a_fire_clean, i_clk, i_rst_n, w_flags.fire, (w_flags.fault == brsm_pkg::FAULT_OK) && !r_skip, "apply fired with fault or while skipping")

endmodule

FILE: src/brsm_obuf.sv
// two-word output buffer between the stack and the result stream
// depends on the assertion macro header
`include "boolean_rule_stack_machine_top_defines.svh"

module brsm_obuf #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_word,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_word,
    input  logic             i_pop_ready
);

    logic             r_v0;
    logic             r_v1;
    logic [WIDTH-1:0] r_q0;
    logic [WIDTH-1:0] r_q1;
    logic             n_v0;
    logic             n_v1;
    logic [WIDTH-1:0] n_q0;
    logic [WIDTH-1:0] n_q1;
    logic             w_pop;

    assign w_pop = r_v0 && i_pop_ready;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (w_pop) begin
            n_v0 = r_v1;
            n_q0 = r_q1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_q0 = i_word;
            end else begin
                n_v1 = 1'b1;
                n_q1 = i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_word  = r_q0;

    `BRSM_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_v1, !i_push, "word pushed into full output buffer")
    `BRSM_ASSERT_NOW(a_order, i_clk, i_rst_n, r_v1, r_v0, "second slot valid with head empty")
    `BRSM_ASSERT_NEXT(a_head_moves, i_clk, i_rst_n, w_pop && r_v1, r_v0 && (r_q0 == $past(r_q1)), "queued word lost on pop")

endmodule

FILE: src/boolean_rule_stack_machine_top.sv
// each result word is registered in the output buffer when its instruction is taken
// throughput: one instruction per cycle while the output buffer has room, set by the shift of the entry cells
// a two-word output buffer lets one more instruction in while a result waits downstream
// reset (i_rst_n low, synchronous) empties the stack, ends skipping and drops buffered words
// stack entry contents are not cleared; only entries below the count are ever read
module boolean_rule_stack_machine_top #(
    parameter int STACK_DEPTH = 16,
    parameter int DEST_BITS   = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // instruction stream
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // mode[2:0], bool_value[3], dest_index[4 +: DEST_BITS], zero pad
    input  logic [((4 + DEST_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // last_item
    input  logic                                    i_s_tlast,
    // result stream
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // apply_fire[0], apply_value[1], apply_dest[2 +: DEST_BITS],
    // fault_code[2 bits], ignored, bailed, zero pad
    output logic [((6 + DEST_BITS + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int ENTRY_BITS = DEST_BITS + 1;
    localparam int OUT_RAW    = 6 + DEST_BITS;
    localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8;

    logic                    w_accept;
    logic                    w_ready;
    logic [2:0]              w_mode;
    logic                    w_bool_value;
    logic [DEST_BITS-1:0]    w_dest_index;
    brsm_pkg::t_stack_cmd    w_cmd;
    logic [ENTRY_BITS-1:0]   w_new_entry;
    brsm_pkg::t_res_flags    w_flags;
    logic [DEST_BITS-1:0]    w_apply_dest;
    logic [OUT_W-1:0]        w_res_word;
    // entry 0 is the top of stack
    logic [ENTRY_BITS-1:0]   w_entry [STACK_DEPTH];

    // unpack the instruction word
    assign w_mode       = i_s_tdata[2:0];
    assign w_bool_value = i_s_tdata[3];
    assign w_dest_index = i_s_tdata[4 +: DEST_BITS];

    assign w_accept   = i_s_tvalid && w_ready;
    assign o_s_tready = w_ready;

    // decode, count and skip state; looks only at the top two cells
    brsm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .DEST_BITS   (DEST_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_mode       (w_mode),
        .i_bool_value (w_bool_value),
        .i_dest_index (w_dest_index),
        .i_last       (i_s_tlast),
        .i_top        (w_entry[0]),
        .i_second     (w_entry[1]),
        .o_cmd        (w_cmd),
        .o_new_entry  (w_new_entry),
        .o_flags      (w_flags),
        .o_dest       (w_apply_dest)
    );

    // chain of entry cells: push shifts down the chain, pop shifts up,
    // the top cell may also load a fresh value while the rest hold or shift
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [ENTRY_BITS-1:0] w_prev;
        logic [ENTRY_BITS-1:0] w_next;
        brsm_pkg::t_cell_op    w_op;

        if (k == 0) begin : g_top
            assign w_prev = w_new_entry;
            assign w_op   = w_cmd.top_op;
        end else begin : g_body
            assign w_prev = w_entry[k-1];
            assign w_op   = w_cmd.rest_op;
        end

        if (k == STACK_DEPTH - 1) begin : g_bottom
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[k+1];
        end

        brsm_cell #(
            .ENTRY_BITS (ENTRY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[k])
        );
    end

    // pack the result word, highest field first
    assign w_res_word = OUT_W'({w_flags.bailed, w_flags.ignored, w_flags.fault,
                                w_apply_dest, w_flags.value, w_flags.fire});

    brsm_obuf #(
        .WIDTH (OUT_W)
    ) u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_word      (w_res_word),
        .o_ready     (w_ready),
        .o_valid     (o_m_tvalid),
        .o_word      (o_m_tdata),
        .i_pop_ready (i_m_tready)
    );

endmodule
